// ===== hw/rtl/srtf_pkg.sv =====
// Shared constants, codes and control types for the shortest-remaining-time scheduler.
package srtf_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int ID_W   = 8;
  localparam int BUR_W  = 16;
  localparam int TIME_W = 32;
  localparam int ORD_W  = 32;

  localparam int IN_W   = ID_W + BUR_W;
  localparam int RES_W  = 1 + 2 + 1 + ID_W + 1 + ID_W + 3 * TIME_W;
  localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

  localparam logic MODE_ADMIT = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [1:0] REJ_NONE = 2'd0;
  localparam logic [1:0] REJ_FULL = 2'd1;
  localparam logic [1:0] REJ_ZERO = 2'd2;

  typedef struct packed {
    logic start;     // input transfer taken this cycle
    logic admit;     // perform an admission
    logic scan;      // examine one slot of the table
    logic update;    // charge one unit to the selected slot
    logic finish;    // work out the waiting time
    logic load_out;  // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic scan_last; // the slot under examination is the last one
    logic out_free;  // output register can take a result this cycle
  } stat_t;

endpackage

// ===== hw/rtl/srtf_ctrl.sv =====
// Control state machine that sequences admissions and scheduling ticks.
module srtf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_mode,
  output logic            in_ready,
  input  srtf_pkg::stat_t stat,
  output srtf_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ADMIT  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_UPDATE = 6'b001000,
    ST_FINISH = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_mode == srtf_pkg::MODE_TICK) ? ST_SCAN : ST_ADMIT;
        end
      end
      ST_ADMIT:  state_next = ST_OUT;
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready     = (state == ST_IDLE);
  assign cmd.start    = (state == ST_IDLE) && in_valid;
  assign cmd.admit    = (state == ST_ADMIT);
  assign cmd.scan     = (state == ST_SCAN);
  assign cmd.update   = (state == ST_UPDATE);
  assign cmd.finish   = (state == ST_FINISH);
  assign cmd.load_out = (state == ST_OUT) && stat.out_free;

`ifndef ASSERT_OFF
  // A tick transfer must go straight into the table scan.
  a_tick_scans: assert property (@(posedge clk) disable iff (rst)
    cmd.start && (in_mode == srtf_pkg::MODE_TICK) |=> (state == ST_SCAN))
    else $error("tick did not start a scan");
`endif

endmodule

// ===== hw/rtl/srtf_dpath.sv =====
// Slot table, sequential selection scan, time keeping and result register.
module srtf_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  srtf_pkg::cmd_t             cmd,
  output srtf_pkg::stat_t            stat,
  input  logic                       in_mode,
  input  logic [srtf_pkg::IN_W-1:0]  in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [srtf_pkg::OUT_W-1:0] out_data
);

  localparam int SW = srtf_pkg::SLOT_W;
  localparam int OUT_W_PAD = srtf_pkg::OUT_W;

  // Slot table: valid bits in flops, payload in a small array.
  logic [srtf_pkg::SLOTS-1:0] slot_valid;
  logic [srtf_pkg::ID_W-1:0]   slot_id        [srtf_pkg::SLOTS];
  logic [srtf_pkg::TIME_W-1:0] slot_arrival   [srtf_pkg::SLOTS];
  logic [srtf_pkg::BUR_W-1:0]  slot_burst     [srtf_pkg::SLOTS];
  logic [srtf_pkg::BUR_W-1:0]  slot_remaining [srtf_pkg::SLOTS];
  logic [srtf_pkg::ORD_W-1:0]  slot_order     [srtf_pkg::SLOTS];

  logic [srtf_pkg::ORD_W-1:0]  admit_counter;
  logic [srtf_pkg::TIME_W-1:0] time_now;

  logic                        item_mode;
  logic [srtf_pkg::ID_W-1:0]   item_id;
  logic [srtf_pkg::BUR_W-1:0]  item_burst;

  logic [SW-1:0]               scan_idx;
  logic                        best_found;
  logic [SW-1:0]               best_idx;
  logic [srtf_pkg::ID_W-1:0]   best_id;
  logic [srtf_pkg::TIME_W-1:0] best_arr;
  logic [srtf_pkg::BUR_W-1:0]  best_bur;
  logic [srtf_pkg::BUR_W-1:0]  best_rem;
  logic [srtf_pkg::ORD_W-1:0]  best_ord;

  logic                        r_admitted;
  logic [1:0]                  r_reject;
  logic                        r_ran_valid;
  logic [srtf_pkg::ID_W-1:0]   r_ran_id;
  logic                        r_done_valid;
  logic [srtf_pkg::ID_W-1:0]   r_done_id;
  logic [srtf_pkg::TIME_W-1:0] r_turn;
  logic [srtf_pkg::TIME_W-1:0] r_wait;

  // Lowest free slot for an admission.
  logic          table_full;
  logic [SW-1:0] free_idx;

  always_comb begin
    free_idx = '0;
    for (int i = srtf_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = SW'(i);
      end
    end
  end
  assign table_full = &slot_valid;

  // Candidate under the scan pointer and its ordering against the best so far.
  logic [srtf_pkg::TIME_W-1:0] rd_arr;
  logic [srtf_pkg::BUR_W-1:0]  rd_bur;
  logic [srtf_pkg::BUR_W-1:0]  rd_rem;
  logic [srtf_pkg::ORD_W-1:0]  rd_ord;
  logic                        ahead;
  logic                        take;

  assign rd_arr = slot_arrival[scan_idx];
  assign rd_bur = slot_burst[scan_idx];
  assign rd_rem = slot_remaining[scan_idx];
  assign rd_ord = slot_order[scan_idx];

  always_comb begin
    if (rd_rem != best_rem) begin
      ahead = rd_rem < best_rem;
    end else if (rd_arr != best_arr) begin
      ahead = rd_arr < best_arr;
    end else if (rd_bur != best_bur) begin
      ahead = rd_bur < best_bur;
    end else begin
      ahead = rd_ord < best_ord;
    end
  end
  assign take = slot_valid[scan_idx] && (!best_found || ahead);

  // Service charge for the selected slot.
  logic [srtf_pkg::BUR_W-1:0]  rem_dec;
  logic [srtf_pkg::TIME_W:0]   wait_diff;

  assign rem_dec   = (best_rem != '0) ? best_rem - 1'b1 : '0;
  assign wait_diff = {1'b0, r_turn} -
                     {{(srtf_pkg::TIME_W + 1 - srtf_pkg::BUR_W){1'b0}}, best_bur};

  assign stat.scan_last = (scan_idx == SW'(srtf_pkg::SLOTS - 1));
  assign stat.out_free  = !out_valid || out_ready;

  // Control flops.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      admit_counter <= '0;
      time_now      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.start && (in_mode == srtf_pkg::MODE_TICK) && (time_now != '1)) begin
        time_now <= time_now + 1'b1;
      end
      if (cmd.admit && (item_burst != '0) && !table_full) begin
        slot_valid[free_idx] <= 1'b1;
        admit_counter        <= admit_counter + 1'b1;
      end
      if (cmd.update && best_found && (rem_dec == '0)) begin
        slot_valid[best_idx] <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Slot payload.
  always_ff @(posedge clk) begin
    if (cmd.admit && (item_burst != '0) && !table_full) begin
      slot_id[free_idx]        <= item_id;
      slot_arrival[free_idx]   <= time_now;
      slot_burst[free_idx]     <= item_burst;
      slot_remaining[free_idx] <= item_burst;
      slot_order[free_idx]     <= admit_counter;
    end
    if (cmd.update && best_found) begin
      slot_remaining[best_idx] <= rem_dec;
    end
  end

  // Item, scan and result payload.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_mode    <= in_mode;
      item_id      <= in_data[srtf_pkg::ID_W-1:0];
      item_burst   <= in_data[srtf_pkg::IN_W-1:srtf_pkg::ID_W];
      scan_idx     <= '0;
      best_found   <= 1'b0;
      r_admitted   <= 1'b0;
      r_reject     <= srtf_pkg::REJ_NONE;
      r_ran_valid  <= 1'b0;
      r_ran_id     <= '0;
      r_done_valid <= 1'b0;
      r_done_id    <= '0;
      r_turn       <= '0;
      r_wait       <= '0;
    end
    if (cmd.admit) begin
      if (item_burst == '0) begin
        r_reject <= srtf_pkg::REJ_ZERO;
      end else if (table_full) begin
        r_reject <= srtf_pkg::REJ_FULL;
      end else begin
        r_admitted <= 1'b1;
      end
    end
    if (cmd.scan) begin
      scan_idx <= scan_idx + 1'b1;
      if (take) begin
        best_found <= 1'b1;
        best_idx   <= scan_idx;
        best_id    <= slot_id[scan_idx];
        best_arr   <= rd_arr;
        best_bur   <= rd_bur;
        best_rem   <= rd_rem;
        best_ord   <= rd_ord;
      end
    end
    if (cmd.update && best_found) begin
      r_ran_valid <= 1'b1;
      r_ran_id    <= best_id;
      if (rem_dec == '0) begin
        r_done_valid <= 1'b1;
        r_done_id    <= best_id;
        r_turn       <= time_now - best_arr;
      end
    end
    if (cmd.finish && r_done_valid) begin
      r_wait <= wait_diff[srtf_pkg::TIME_W] ? '0 : wait_diff[srtf_pkg::TIME_W-1:0];
    end
    if (cmd.load_out) begin
      out_data <= OUT_W_PAD'({time_now, r_wait, r_turn, r_done_id, r_done_valid,
                              r_ran_id, r_ran_valid, r_reject, r_admitted});
    end
  end

`ifndef ASSERT_OFF
  // The time counter never runs backward outside reset.
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (time_now >= $past(time_now)))
    else $error("time counter decreased");

  // A result is only moved into the output register when that register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // A finished process leaves the table.
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.update && best_found && (rem_dec == '0) |=> !slot_valid[best_idx])
    else $error("finished slot still valid");

  // Only a tick item ever runs a scan.
  a_scan_tick: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (item_mode == srtf_pkg::MODE_TICK))
    else $error("scan during an admission");
`endif

endmodule

// ===== hw/rtl/srtf_scheduler.sv =====
// Top level of the shortest-remaining-time-first scheduler.
// An admit result passes the ADMIT state and enters the output register from OUT; a tick result
// passes SCAN, UPDATE and FINISH first, since one slot per cycle is scanned, then OUT.
// One item is in work at a time; the next input transfer is taken the cycle after the result
// has moved into the output register, which OUT waits for while that register is still full.
// Synchronous active-high reset empties the table and clears time and admission count.
module srtf_scheduler (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // From bit 0: proc_id[7:0], burst[23:8].
  input  logic [srtf_pkg::IN_W-1:0]  s_axis_tdata,
  // Bit 0: mode (0 admit, 1 tick).
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // From bit 0: admitted[0], reject_code[2:1], ran_valid[3], ran_id[11:4], done_valid[12],
  // done_id[20:13], turnaround_time[52:21], waiting_time[84:53], current_time[116:85],
  // zero padding[119:117].
  output logic [srtf_pkg::OUT_W-1:0] m_axis_tdata
);

  srtf_pkg::cmd_t  cmd;
  srtf_pkg::stat_t stat;

  // The controller sequences each item: admission in one step, or a scan over all slots
  // followed by the service update and the waiting time computation.
  srtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the slot table, the time counter and the output register, which
  // keeps a finished result while the input side is free again.
  srtf_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_mode   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
